// ----- rtl/assert_macros.svh -----
// Assertion macros used by the parse step RTL (mpsp_parse).
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on clk_i, off while rst_ni is low.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i, off while rst_ni is low.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mpsp_pkg.sv -----
// Types and constants of the MQTT control packet stream parser.
`default_nettype none
package mpsp_pkg;

  // Maximum number of remaining-length digits
  localparam int unsigned LengthDigits = 4;

  // Tag of each result
  typedef enum logic [3:0] {
    KIND_HEADER    = 4'd0,
    KIND_REMLEN    = 4'd1,
    KIND_CFLAGS    = 4'd2,
    KIND_KEEPALIVE = 4'd3,
    KIND_STRLEN    = 4'd4,
    KIND_CID       = 4'd5,
    KIND_WILLTOPIC = 4'd6,
    KIND_WILLMSG   = 4'd7,
    KIND_USER      = 4'd8,
    KIND_PASS      = 4'd9,
    KIND_TOPIC     = 4'd10,
    KIND_PKTID     = 4'd11,
    KIND_PAYLOAD   = 4'd12,
    KIND_QOS       = 4'd13,
    KIND_SKIPPED   = 4'd14,
    KIND_ERROR     = 4'd15
  } field_kind_e;

  // Control packet types that steer the body layout
  localparam logic [3:0] TypeConnect     = 4'd1;
  localparam logic [3:0] TypePublish     = 4'd3;
  localparam logic [3:0] TypePuback      = 4'd4;
  localparam logic [3:0] TypePubcomp     = 4'd7;
  localparam logic [3:0] TypeSubscribe   = 4'd8;
  localparam logic [3:0] TypeUnsubscribe = 4'd10;
  localparam logic [3:0] TypePingreq     = 4'd12;
  localparam logic [3:0] TypeDisconnect  = 4'd14;

  // Parse phases; string phases are PhStr0 + 3*group + position
  localparam logic [4:0] PhHdr     = 5'd0;
  localparam logic [4:0] PhLen     = 5'd1;
  localparam logic [4:0] PhCskip   = 5'd2;
  localparam logic [4:0] PhCflags  = 5'd3;
  localparam logic [4:0] PhKaHi    = 5'd4;
  localparam logic [4:0] PhKaLo    = 5'd5;
  localparam logic [4:0] PhStr0    = 5'd6;
  localparam logic [4:0] PhWill    = 5'd9;
  localparam logic [4:0] PhWillMsg = 5'd12;
  localparam logic [4:0] PhUser    = 5'd15;
  localparam logic [4:0] PhPass    = 5'd18;
  localparam logic [4:0] PhTopic   = 5'd21;
  localparam logic [4:0] PhStrEnd  = 5'd23;
  localparam logic [4:0] PhPidHi   = 5'd24;
  localparam logic [4:0] PhPidLo   = 5'd25;
  localparam logic [4:0] PhPayload = 5'd26;
  localparam logic [4:0] PhQos     = 5'd27;
  localparam logic [4:0] PhTrail   = 5'd28;
  localparam logic [4:0] PhSkip    = 5'd29;

  // Connect flag bits
  localparam int unsigned FlagWill = 2;
  localparam int unsigned FlagPass = 6;
  localparam int unsigned FlagUser = 7;

  // Protocol name and level bytes skipped in CONNECT
  localparam logic [2:0] ConnectSkip = 3'd7;

  // One tagged result
  typedef struct packed {
    field_kind_e kind;
    logic [27:0] value;
    logic [3:0]  pkt;
    logic        last;
    logic        bad;
  } result_t;

endpackage
`default_nettype wire

// ----- rtl/mpsp_in_stage.sv -----
// Input register of the parser: holds one byte until the parse step takes it.
`default_nettype none
module mpsp_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       valid_i,
  output logic            ready_o,
  input  wire logic [7:0] data_i,
  input  wire logic       take_i,   // parse step consumes the held byte
  output logic            valid_o,
  output logic [7:0]      data_o
);

  logic       valid_q;
  logic [7:0] data_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Byte holding register
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mpsp_parse.sv -----
// Parser state and the combinational step that decodes one stream byte.
`default_nettype none
module mpsp_parse (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,   // a byte is processed this cycle
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output mpsp_pkg::result_t res_o
);

  `include "assert_macros.svh"

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  type_q, type_d;
  logic [1:0]  qos_q, qos_d;
  logic [7:0]  cflags_q, cflags_d;
  logic [27:0] rem_q, rem_d;
  logic [27:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [15:0] word_q, word_d;
  logic [15:0] strl_q, strl_d;
  logic [2:0]  skip_q, skip_d;

  // Phase from the password field on: password if flagged, else trailing bytes
  function automatic logic [4:0] from_pass(input logic [7:0] fl);
    return fl[mpsp_pkg::FlagPass] ? mpsp_pkg::PhPass : mpsp_pkg::PhTrail;
  endfunction

  // Phase from the user name field on: user name if flagged, else as from_pass
  function automatic logic [4:0] from_user(input logic [7:0] fl);
    return fl[mpsp_pkg::FlagUser] ? mpsp_pkg::PhUser : from_pass(fl);
  endfunction

  // Phase that follows a finished string of the given group
  function automatic logic [4:0] after_string(input logic [2:0] g, input logic [3:0] ty,
                                              input logic [1:0] qs, input logic [7:0] fl);
    logic [4:0] nx;
    unique case (g)
      3'd0: nx = fl[mpsp_pkg::FlagWill] ? mpsp_pkg::PhWill : from_user(fl);
      3'd1: nx = mpsp_pkg::PhWillMsg;
      3'd2: nx = from_user(fl);
      3'd3: nx = from_pass(fl);
      3'd4: nx = mpsp_pkg::PhTrail;
      default: begin
        if (ty == mpsp_pkg::TypePublish) begin
          nx = (qs != 2'd0) ? mpsp_pkg::PhPidHi : mpsp_pkg::PhPayload;
        end else if (ty == mpsp_pkg::TypeSubscribe) begin
          nx = mpsp_pkg::PhQos;
        end else begin
          nx = mpsp_pkg::PhTopic;
        end
      end
    endcase
    return nx;
  endfunction

  // Phases at which the packet may legally end
  function automatic logic ok_end(input logic [4:0] ph, input logic [3:0] ty);
    return (ph == mpsp_pkg::PhTrail) || (ph == mpsp_pkg::PhSkip) ||
           (ph == mpsp_pkg::PhPayload) ||
           ((ph == mpsp_pkg::PhTopic) &&
            ((ty == mpsp_pkg::TypeSubscribe) || (ty == mpsp_pkg::TypeUnsubscribe)));
  endfunction

  // First body phase of a packet type
  function automatic logic [4:0] body_start(input logic [3:0] ty);
    logic [4:0] nx;
    if (ty == mpsp_pkg::TypeConnect) begin
      nx = mpsp_pkg::PhCskip;
    end else if (ty == mpsp_pkg::TypePublish) begin
      nx = mpsp_pkg::PhTopic;
    end else if ((ty >= mpsp_pkg::TypePuback && ty <= mpsp_pkg::TypePubcomp) ||
                 ty == mpsp_pkg::TypeSubscribe || ty == mpsp_pkg::TypeUnsubscribe) begin
      nx = mpsp_pkg::PhPidHi;
    end else if (ty >= mpsp_pkg::TypePingreq && ty <= mpsp_pkg::TypeDisconnect) begin
      nx = mpsp_pkg::PhTrail;
    end else begin
      nx = mpsp_pkg::PhSkip;
    end
    return nx;
  endfunction

  // Step logic
  logic [1:0]  dcnt;
  logic [2:0]  dcnt_inc;
  logic [27:0] digit;
  logic [27:0] acc_new;
  logic [4:0]  start_ph;
  logic [4:0]  off, pos_w;
  logic [2:0]  grp;
  logic [1:0]  pos;
  logic        is_last;
  logic        have;
  logic        mal;
  logic [4:0]  nx;
  logic [15:0] wnew;
  logic [15:0] sdec;
  logic [2:0]  kdec;
  mpsp_pkg::field_kind_e kind;
  logic [27:0] val;

  always_comb begin
    phase_d  = phase_q;
    type_d   = type_q;
    qos_d    = qos_q;
    cflags_d = cflags_q;
    rem_d    = rem_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    word_d   = word_q;
    strl_d   = strl_q;
    skip_d   = skip_q;
    res_valid_o = 1'b0;
    res_o.kind  = mpsp_pkg::KIND_ERROR;
    res_o.value = 28'd0;
    res_o.pkt   = type_q;
    res_o.last  = 1'b0;
    res_o.bad   = 1'b0;

    // Remaining-length digit placement
    dcnt     = (cnt_q > 3'd3) ? 2'd3 : cnt_q[1:0];
    dcnt_inc = {1'b0, dcnt} + 3'd1;
    unique case (dcnt)
      2'd0: digit = {21'd0, byte_i[6:0]};
      2'd1: digit = {14'd0, byte_i[6:0], 7'd0};
      2'd2: digit = {7'd0, byte_i[6:0], 14'd0};
      default: digit = {byte_i[6:0], 21'd0};
    endcase
    acc_new  = acc_q | digit;
    start_ph = body_start(type_q);

    // String phase split into group and position
    off = phase_q - mpsp_pkg::PhStr0;
    if (off >= 5'd15) grp = 3'd5;
    else if (off >= 5'd12) grp = 3'd4;
    else if (off >= 5'd9) grp = 3'd3;
    else if (off >= 5'd6) grp = 3'd2;
    else if (off >= 5'd3) grp = 3'd1;
    else grp = 3'd0;
    pos_w = off - {1'b0, grp, 1'b0} - {2'd0, grp};
    pos   = pos_w[1:0];

    is_last = (rem_q <= 28'd1);
    have    = 1'b0;
    mal     = 1'b0;
    nx      = phase_q;
    kind    = mpsp_pkg::KIND_ERROR;
    val     = 28'd0;
    wnew    = word_q | {8'd0, byte_i};
    sdec    = (strl_q != 16'd0) ? strl_q - 16'd1 : strl_q;
    kdec    = (skip_q != 3'd0) ? skip_q - 3'd1 : skip_q;

    if (step_i) begin
      if (phase_q == mpsp_pkg::PhHdr || phase_q > mpsp_pkg::PhSkip) begin
        // Fixed header byte
        type_d  = byte_i[7:4];
        qos_d   = byte_i[2:1];
        acc_d   = 28'd0;
        cnt_d   = 3'd0;
        phase_d = mpsp_pkg::PhLen;
        res_valid_o = 1'b1;
        res_o.kind  = mpsp_pkg::KIND_HEADER;
        res_o.value = {20'd0, byte_i};
        res_o.pkt   = byte_i[7:4];
      end else if (phase_q == mpsp_pkg::PhLen) begin
        // Remaining-length digit
        acc_d = acc_new;
        cnt_d = dcnt_inc;
        if (byte_i[7]) begin
          if (dcnt_inc >= 3'(mpsp_pkg::LengthDigits)) begin
            phase_d = mpsp_pkg::PhHdr;
            res_valid_o = 1'b1;
            res_o.kind  = mpsp_pkg::KIND_ERROR;
            res_o.value = acc_new;
            res_o.last  = 1'b1;
            res_o.bad   = 1'b1;
          end
        end else begin
          rem_d = acc_new;
          if (type_q == mpsp_pkg::TypeConnect) begin
            skip_d = mpsp_pkg::ConnectSkip;
          end
          res_valid_o = 1'b1;
          res_o.kind  = mpsp_pkg::KIND_REMLEN;
          res_o.value = acc_new;
          if (acc_new == 28'd0) begin
            phase_d    = mpsp_pkg::PhHdr;
            res_o.last = 1'b1;
            res_o.bad  = !ok_end(start_ph, type_q);
          end else begin
            phase_d = start_ph;
          end
        end
      end else begin
        // Body byte
        rem_d = is_last ? 28'd0 : rem_q - 28'd1;
        if (phase_q >= mpsp_pkg::PhStr0 && phase_q <= mpsp_pkg::PhStrEnd) begin
          unique case (pos)
            2'd0: begin
              word_d = {byte_i, 8'd0};
              nx     = phase_q + 5'd1;
            end
            2'd1: begin
              word_d = wnew;
              strl_d = wnew;
              have   = 1'b1;
              kind   = mpsp_pkg::KIND_STRLEN;
              val    = {12'd0, wnew};
              nx     = (wnew != 16'd0) ? phase_q + 5'd1
                                       : after_string(grp, type_q, qos_q, cflags_q);
            end
            default: begin
              have   = 1'b1;
              kind   = mpsp_pkg::field_kind_e'(4'(grp) + mpsp_pkg::KIND_CID);
              val    = {20'd0, byte_i};
              strl_d = sdec;
              if (sdec == 16'd0) begin
                nx = after_string(grp, type_q, qos_q, cflags_q);
              end
            end
          endcase
        end else begin
          unique case (phase_q)
            mpsp_pkg::PhCskip: begin
              skip_d = kdec;
              if (kdec == 3'd0) nx = mpsp_pkg::PhCflags;
            end
            mpsp_pkg::PhCflags: begin
              cflags_d = byte_i;
              have     = 1'b1;
              kind     = mpsp_pkg::KIND_CFLAGS;
              val      = {20'd0, byte_i};
              nx       = mpsp_pkg::PhKaHi;
            end
            mpsp_pkg::PhKaHi, mpsp_pkg::PhPidHi: begin
              word_d = {byte_i, 8'd0};
              nx     = phase_q + 5'd1;
            end
            mpsp_pkg::PhKaLo: begin
              word_d = wnew;
              have   = 1'b1;
              kind   = mpsp_pkg::KIND_KEEPALIVE;
              val    = {12'd0, wnew};
              nx     = mpsp_pkg::PhStr0;
            end
            mpsp_pkg::PhPidLo: begin
              word_d = wnew;
              have   = 1'b1;
              kind   = mpsp_pkg::KIND_PKTID;
              val    = {12'd0, wnew};
              if (type_q == mpsp_pkg::TypePublish) begin
                nx = mpsp_pkg::PhPayload;
              end else if (type_q == mpsp_pkg::TypeSubscribe ||
                           type_q == mpsp_pkg::TypeUnsubscribe) begin
                nx = mpsp_pkg::PhTopic;
              end else begin
                nx = mpsp_pkg::PhTrail;
              end
            end
            mpsp_pkg::PhPayload: begin
              have = 1'b1;
              kind = mpsp_pkg::KIND_PAYLOAD;
              val  = {20'd0, byte_i};
            end
            mpsp_pkg::PhQos: begin
              have = 1'b1;
              kind = mpsp_pkg::KIND_QOS;
              val  = {20'd0, byte_i};
              nx   = mpsp_pkg::PhTopic;
            end
            mpsp_pkg::PhTrail: begin
              have = 1'b1;
              kind = mpsp_pkg::KIND_SKIPPED;
              val  = {20'd0, byte_i};
              mal  = 1'b1;
            end
            default: begin
              have = 1'b1;
              kind = mpsp_pkg::KIND_SKIPPED;
              val  = {20'd0, byte_i};
            end
          endcase
        end

        // Close the packet on its last body byte
        if (is_last) begin
          phase_d     = mpsp_pkg::PhHdr;
          res_valid_o = 1'b1;
          res_o.kind  = have ? kind : mpsp_pkg::KIND_ERROR;
          res_o.value = have ? val : 28'd0;
          res_o.last  = 1'b1;
          res_o.bad   = mal || !ok_end(nx, type_q);
        end else begin
          phase_d     = nx;
          res_valid_o = have;
          res_o.kind  = kind;
          res_o.value = val;
          res_o.bad   = mal;
        end
      end
    end
  end

  // Parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= mpsp_pkg::PhHdr;
      type_q   <= 4'd0;
      qos_q    <= 2'd0;
      cflags_q <= 8'd0;
      rem_q    <= 28'd0;
      acc_q    <= 28'd0;
      cnt_q    <= 3'd0;
      word_q   <= 16'd0;
      strl_q   <= 16'd0;
      skip_q   <= 3'd0;
    end else begin
      phase_q  <= phase_d;
      type_q   <= type_d;
      qos_q    <= qos_d;
      cflags_q <= cflags_d;
      rem_q    <= rem_d;
      acc_q    <= acc_d;
      cnt_q    <= cnt_d;
      word_q   <= word_d;
      strl_q   <= strl_d;
      skip_q   <= skip_d;
    end
  end

  // A header byte always leads into the length phase
  `ASSERT_NEXT(a_hdr_to_len, step_i && phase_q == mpsp_pkg::PhHdr, phase_q == mpsp_pkg::PhLen, "header byte did not start length decode")
  // A closing result always returns to header hunting
  `ASSERT_NEXT(a_end_to_hdr, step_i && res_valid_o && res_o.last, phase_q == mpsp_pkg::PhHdr, "packet end did not rearm header")
  // Length digit counter stays within the digit limit
  `ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= 3'(mpsp_pkg::LengthDigits), "length digit count out of range")
  // An error result is only ever final
  `ASSERT_IMPL(a_err_final, step_i && res_valid_o && res_o.kind == mpsp_pkg::KIND_ERROR, res_o.last, "error result not closing packet")

endmodule
`default_nettype wire

// ----- rtl/mpsp_out_stage.sv -----
// Result register of the parser: holds one tagged result until taken.
`default_nettype none
module mpsp_out_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              load_i,   // step produced a result
  input  wire mpsp_pkg::result_t res_i,
  output logic                   free_o,   // register may take a new result
  output logic                   valid_o,
  input  wire logic              ready_i,
  output mpsp_pkg::result_t      res_o
);

  logic              valid_q;
  mpsp_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  // Result holding register
  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      res_q <= res_i;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mqtt_packet_stream_parser.sv -----
// An accepted byte is held in the input register, then its result in the result register.
// Throughput: one byte per cycle; the parse step is combinational between the
//   input register and the result register, and stalls only on result backpressure.
// Bytes that complete no field are consumed without a result.
// Reset (rst_ni low, asynchronous) empties both registers and rearms header search.
`default_nettype none
module mqtt_packet_stream_parser (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [27:0] field_value, [31:28] zero
  output logic [8:0]       m_axis_tuser,   // [3:0] field_kind, [7:4] packet_kind, [8] malformed
  output logic             m_axis_tlast    // packet_end
);

  logic              in_valid;
  logic [7:0]        in_byte;
  logic              out_free;
  logic              step;
  logic              res_valid;
  mpsp_pkg::result_t res;
  mpsp_pkg::result_t out_res;

  // Step whenever a byte is held and the result register can take a result
  assign step = in_valid && out_free;

  mpsp_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .data_i  (s_axis_tdata),
    .take_i  (step),
    .valid_o (in_valid),
    .data_o  (in_byte)
  );

  mpsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mpsp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (res_valid),
    .res_i   (res),
    .free_o  (out_free),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (out_res)
  );

  // Pack the result onto the master side
  assign m_axis_tdata = {4'd0, out_res.value};
  assign m_axis_tuser = {out_res.bad, out_res.pkt, out_res.kind};
  assign m_axis_tlast = out_res.last;

endmodule
`default_nettype wire
